>>> src/pcwtf_pkg.sv
// shared widths, codes and defaults for the program-counter watch trace filter
`default_nettype none

package pcwtf_pkg;

  localparam int unsigned WatchEntriesDef = 16;

  localparam int unsigned AddrW   = 64;
  localparam int unsigned IdW     = 32;
  localparam int unsigned CountW  = 64;
  localparam int unsigned TotalW  = 5;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned CoreW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned EntryW  = 9;

  localparam logic [TotalW-1:0] WatchTotalRst = TotalW'(1);

  typedef enum logic [0:0] {
    ACT_LOAD = 1'b0,
    ACT_EXEC = 1'b1
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EVENT_BUDGET = 2'd0,
    CFG_WATCH_BUDGET = 2'd1,
    CFG_WATCH_TOTAL  = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

endpackage

`default_nettype wire

>>> src/pcwtf_match.sv
// parallel compare of an executed address against the watch table, lowest slot wins
`default_nettype none

module pcwtf_match
  import pcwtf_pkg::*;
#(
  parameter int unsigned WATCH_ENTRIES = WatchEntriesDef,
  localparam int unsigned IdxW = (WATCH_ENTRIES > 1) ? $clog2(WATCH_ENTRIES) : 1
) (
  input  logic [AddrW-1:0]  address_i,
  input  logic [AddrW-1:0]  table_addr_i [WATCH_ENTRIES],
  input  logic [TotalW-1:0] in_use_i,
  output logic              found_o,
  output logic [IdxW-1:0]   index_o
);

  logic [WATCH_ENTRIES-1:0] match;

  always_comb begin
    for (int unsigned i = 0; i < WATCH_ENTRIES; i++) begin
      match[i] = (EntryW'(i) < EntryW'(in_use_i)) && (table_addr_i[i] == address_i);
    end
  end

  // priority encode, lowest matching slot
  always_comb begin
    found_o = 1'b0;
    index_o = '0;
    for (int i = WATCH_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_o = 1'b1;
        index_o = IdxW'(i);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/pc_watch_trace_filter_unit.sv
// top level of the program-counter watch trace filter
`default_nettype none

// Each item passes an input register and then the table search, budget checks and counter
// update before landing in the result register, so the unit takes one item per cycle unless
// a result waits on out_ready, and registers the result as the item leaves the input register.
// The cycle time is set by the address search over all table entries followed by the per-watch
// counter read, the 64-bit budget compare and the counter increment. A load item writes the
// table when it leaves the input register, so an execute item that follows it in the next
// cycle already sees the new entry. The watch table holds whatever was loaded; entries never
// loaded must not be placed in use.

module pc_watch_trace_filter_unit
  import pcwtf_pkg::*;
#(
  parameter int unsigned WATCH_ENTRIES = WatchEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action_i,
  input  logic [SlotW-1:0]   entry_slot_i,
  input  logic [AddrW-1:0]   address_i,
  input  logic [IdW-1:0]     entry_id_i,
  input  logic [CoreW-1:0]   core_index_i,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit_o,
  output logic               emitted_o,
  output logic [IdW-1:0]     trace_word_o,
  output logic               watch_truncated_o,
  output logic               budget_hit_o,
  output logic               error_seen_o,
  output logic [CountW-1:0]  event_total_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CountW-1:0]  cfg_data
);

  localparam int unsigned IdxW = (WATCH_ENTRIES > 1) ? $clog2(WATCH_ENTRIES) : 1;

  // configuration
  logic [CountW-1:0] event_budget_q;
  logic [CountW-1:0] watch_budget_q;
  logic [TotalW-1:0] watch_total_q;

  // input register
  logic              s1_valid_q;
  logic              action_q;
  logic [SlotW-1:0]  slot_q;
  logic [AddrW-1:0]  addr_q;
  logic [IdW-1:0]    id_q;
  logic [CoreW-1:0]  core_q;

  // table and counters
  logic [AddrW-1:0]  tab_addr_q [WATCH_ENTRIES];
  logic [IdW-1:0]    tab_id_q   [WATCH_ENTRIES];
  logic [CountW-1:0] watch_cnt_q [WATCH_ENTRIES];
  logic [WATCH_ENTRIES-1:0] trunc_q;
  logic [CountW-1:0] emitted_cnt_q;
  logic              budget_flag_q;
  logic              error_flag_q;

  // result register
  logic              out_valid_q, out_valid_d;
  logic              hit_q;
  logic              emitted_q;
  logic [IdW-1:0]    word_q;
  logic              trunc_out_q;
  logic              budget_out_q;
  logic              error_out_q;
  logic [CountW-1:0] total_out_q;

  logic              advance;
  logic              is_exec;
  logic [TotalW-1:0] in_use;
  logic              found;
  logic [IdxW-1:0]   match_idx;
  logic [IdW-1:0]    match_id;
  logic [IdxW-1:0]   watch_idx;
  logic              id_ok;
  logic              budget_spent;
  logic              watch_spent;
  logic              core_ok;
  logic              set_budget;
  logic              set_error;
  logic              set_trunc;
  logic              emit_now;
  logic              load_ok;
  logic [IdxW-1:0]   load_idx;
  logic [EntryW-1:0] slot_ext;
  logic              budget_flag_d;
  logic              error_flag_d;
  logic [CountW-1:0] emitted_cnt_d;
  logic              trunc_now;

  assign advance   = s1_valid_q && (!out_valid_q || out_ready);
  assign in_ready  = !s1_valid_q || advance;
  assign cfg_ready = 1'b1;
  assign is_exec   = (action_q == ACT_EXEC);

  assign in_use = (EntryW'(watch_total_q) > EntryW'(WATCH_ENTRIES)) ?
                  TotalW'(WATCH_ENTRIES) : watch_total_q;

  pcwtf_match #(
    .WATCH_ENTRIES(WATCH_ENTRIES)
  ) u_match (
    .address_i   (addr_q),
    .table_addr_i(tab_addr_q),
    .in_use_i    (in_use),
    .found_o     (found),
    .index_o     (match_idx)
  );

  // checks in order of priority
  always_comb begin
    match_id     = tab_id_q[match_idx];
    watch_idx    = match_id[IdxW-1:0];
    id_ok        = IdW'(in_use) > match_id;
    budget_spent = emitted_cnt_q >= event_budget_q;
    watch_spent  = watch_cnt_q[watch_idx] >= watch_budget_q;
    core_ok      = (core_q == '0);
    set_budget   = 1'b0;
    set_error    = 1'b0;
    set_trunc    = 1'b0;
    emit_now     = 1'b0;
    if (is_exec && found) begin
      priority if (budget_spent) begin
        set_budget = 1'b1;
      end else if (!id_ok) begin
        set_error = 1'b1;
      end else if (watch_spent) begin
        set_trunc = 1'b1;
      end else if (!core_ok) begin
        set_error = 1'b1;
      end else begin
        emit_now = 1'b1;
      end
    end
    budget_flag_d = budget_flag_q || set_budget;
    error_flag_d  = error_flag_q || set_error;
    emitted_cnt_d = emit_now ? (emitted_cnt_q + CountW'(1)) : emitted_cnt_q;
    trunc_now     = is_exec && found && id_ok && (trunc_q[watch_idx] || set_trunc);
  end

  assign slot_ext = EntryW'(slot_q);
  assign load_idx = slot_ext[IdxW-1:0];
  assign load_ok  = !is_exec && (slot_ext < EntryW'(WATCH_ENTRIES));

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_budget_q <= '1;
      watch_budget_q <= '1;
      watch_total_q  <= WatchTotalRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_EVENT_BUDGET: event_budget_q <= cfg_data;
        CFG_WATCH_BUDGET: watch_budget_q <= cfg_data;
        CFG_WATCH_TOTAL:  watch_total_q  <= cfg_data[TotalW-1:0];
        CFG_UNUSED:       ;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid && in_ready) begin
      action_q <= action_i;
      slot_q   <= entry_slot_i;
      addr_q   <= address_i;
      id_q     <= entry_id_i;
      core_q   <= core_index_i;
    end
  end

  // table contents, no reset
  always_ff @(posedge clk_i) begin
    if (advance && load_ok) begin
      tab_addr_q[load_idx] <= addr_q;
      tab_id_q[load_idx]   <= id_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < WATCH_ENTRIES; i++) begin
        watch_cnt_q[i] <= '0;
      end
      trunc_q       <= '0;
      emitted_cnt_q <= '0;
      budget_flag_q <= 1'b0;
      error_flag_q  <= 1'b0;
    end else if (advance) begin
      if (emit_now) begin
        watch_cnt_q[watch_idx] <= watch_cnt_q[watch_idx] + CountW'(1);
      end
      if (set_trunc) begin
        trunc_q[watch_idx] <= 1'b1;
      end
      emitted_cnt_q <= emitted_cnt_d;
      budget_flag_q <= budget_flag_d;
      error_flag_q  <= error_flag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hit_q        <= is_exec && found;
      emitted_q    <= emit_now;
      word_q       <= (is_exec && found) ? match_id : '0;
      trunc_out_q  <= trunc_now;
      budget_out_q <= budget_flag_d;
      error_out_q  <= error_flag_d;
      total_out_q  <= emitted_cnt_d;
    end
  end

  assign out_valid         = out_valid_q;
  assign hit_o             = hit_q;
  assign emitted_o         = emitted_q;
  assign trace_word_o      = word_q;
  assign watch_truncated_o = trunc_out_q;
  assign budget_hit_o      = budget_out_q;
  assign error_seen_o      = error_out_q;
  assign event_total_o     = total_out_q;

  a_emit_needs_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && emitted_q) |-> hit_q)
    else $error("item emitted without a hit");

  a_count_only_on_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && emit_now) |=> $stable(emitted_cnt_q))
    else $error("event count moved without an emission");

  a_budget_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    budget_flag_q |=> budget_flag_q)
    else $error("budget flag cleared");

  a_error_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_flag_q |=> error_flag_q)
    else $error("error flag cleared");

endmodule

`default_nettype wire
